// ===== hdl/rgbtc_pkg.sv =====
`timescale 1ns / 1ps

package rgbtc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_16   = 2'd1,
    MODE_256  = 2'd2,
    MODE_TRUE = 2'd3
  } color_mode_e;

  typedef enum logic [1:0] {
    FORM_NONE    = 2'd0,
    FORM_DIRECT  = 2'd1,
    FORM_PALETTE = 2'd2,
    FORM_TRUE    = 2'd3
  } form_e;

  // target codes, values 2 and 3 behave as underline
  localparam logic [1:0] TGT_FG = 2'd0;
  localparam logic [1:0] TGT_BG = 2'd1;

  typedef struct packed {
    logic       is_named;
    logic [3:0] named_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] target;
  } in_item_t;

  typedef struct packed {
    logic       emit;
    form_e      form;
    logic [6:0] sgr_code;
    logic [7:0] palette_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  // load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_ld_t;

  localparam logic [6:0] SGR_FG_BASE = 7'd30;
  localparam logic [6:0] SGR_BG_BASE = 7'd40;
  localparam logic [6:0] SGR_BRIGHT  = 7'd60;
  localparam logic [6:0] SGR_EXT_FG  = 7'd38;
  localparam logic [6:0] SGR_EXT_BG  = 7'd48;
  localparam logic [6:0] SGR_EXT_UL  = 7'd58;
  localparam logic [6:0] SGR_DIRECT_MAX = 7'd107;

  localparam logic [7:0] CUBE_BASE = 8'd16;
  localparam logic [7:0] GRAY_BASE = 8'd232;
  localparam logic [7:0] GRAY_OFS  = 8'd3;
  localparam logic [7:0] GRAY_FIRST = 8'd8;
  localparam logic [4:0] GRAY_MAX_STEP = 5'd23;

  // floor(x/3) = (x*683) >> 11 for x below 2048
  localparam logic [9:0] AVG_RECIP = 10'd683;
  // floor(x/10) = (x*205) >> 11 for x below 256
  localparam logic [7:0] STEP_RECIP = 8'd205;
  localparam int RECIP_SHIFT = 11;

  // distinct channel values of the sixteen reference colors
  localparam int Q16_NLVL = 7;
  localparam logic [7:0] Q16_LEVEL [Q16_NLVL] = '{
    8'd0, 8'd92, 8'd127, 8'd205, 8'd229, 8'd238, 8'd255
  };

  // per reference color: level index of red, green, blue
  localparam logic [2:0] Q16_MAP [16][3] = '{
    '{3'd0, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}, '{3'd0, 3'd3, 3'd0}, '{3'd3, 3'd3, 3'd0},
    '{3'd0, 3'd0, 3'd5}, '{3'd3, 3'd0, 3'd3}, '{3'd0, 3'd3, 3'd3}, '{3'd4, 3'd4, 3'd4},
    '{3'd2, 3'd2, 3'd2}, '{3'd6, 3'd0, 3'd0}, '{3'd0, 3'd6, 3'd0}, '{3'd6, 3'd6, 3'd0},
    '{3'd1, 3'd1, 3'd6}, '{3'd6, 3'd0, 3'd6}, '{3'd0, 3'd6, 3'd6}, '{3'd6, 3'd6, 3'd6}
  };

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [15:0] square8(input logic [7:0] d);
    return 16'(d) * 16'(d);
  endfunction

  // cube level by midpoint thresholds
  function automatic logic [2:0] cube_level_of(input logic [7:0] v);
    logic [2:0] lv;
    lv = 3'd0;
    if (v >= 8'd48)  lv = 3'd1;
    if (v >= 8'd115) lv = 3'd2;
    if (v >= 8'd155) lv = 3'd3;
    if (v >= 8'd195) lv = 3'd4;
    if (v >= 8'd235) lv = 3'd5;
    return lv;
  endfunction

  function automatic logic [7:0] cube_value(input logic [2:0] lv);
    logic [7:0] v;
    case (lv)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] direct_code(input logic [3:0] idx, input logic [1:0] tgt);
    logic [6:0] code;
    code = (tgt == TGT_BG) ? SGR_BG_BASE : SGR_FG_BASE;
    if (idx[3]) code = code + SGR_BRIGHT;
    return code + {4'd0, idx[2:0]};
  endfunction

endpackage

// ===== hdl/rgbtc_q16.sv =====
`timescale 1ns / 1ps

module rgbtc_q16 import rgbtc_pkg::*; (
  input  logic       clk_i,
  input  pipe_ld_t   ld_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [3:0] idx_o
);

  logic [7:0]  chan [3];
  logic [15:0] sq_d [3][Q16_NLVL];
  logic [15:0] sq_q [3][Q16_NLVL];
  logic [17:0] dist_d [16];
  logic [17:0] dist_q [16];
  logic [17:0] grp_dist_d [4];
  logic [3:0]  grp_idx_d [4];
  logic [17:0] grp_dist_q [4];
  logic [3:0]  grp_idx_q [4];
  logic [17:0] pair_dist_d [2];
  logic [3:0]  pair_idx_d [2];
  logic [17:0] pair_dist_q [2];
  logic [3:0]  pair_idx_q [2];
  logic [3:0]  idx_d;
  logic [3:0]  idx_q;

  assign chan[0] = red_i;
  assign chan[1] = green_i;
  assign chan[2] = blue_i;

  // stage 1: squared distance of each channel to each distinct level
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int l = 0; l < Q16_NLVL; l++) begin
        sq_d[c][l] = square8(abs_diff(chan[c], Q16_LEVEL[l]));
      end
    end
  end

  // stage 2: distance to every reference color
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      dist_d[i] = 18'(sq_q[0][Q16_MAP[i][0]]) + 18'(sq_q[1][Q16_MAP[i][1]])
                + 18'(sq_q[2][Q16_MAP[i][2]]);
    end
  end

  // stage 3: best of each group of four, lower index kept on ties
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_dist_d[g] = dist_q[4*g];
      grp_idx_d[g]  = 4'(4*g);
      for (int k = 1; k < 4; k++) begin
        if (dist_q[4*g+k] < grp_dist_d[g]) begin
          grp_dist_d[g] = dist_q[4*g+k];
          grp_idx_d[g]  = 4'(4*g+k);
        end
      end
    end
  end

  // stage 4: best of each pair of groups
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (grp_dist_q[2*p+1] < grp_dist_q[2*p]) begin
        pair_dist_d[p] = grp_dist_q[2*p+1];
        pair_idx_d[p]  = grp_idx_q[2*p+1];
      end else begin
        pair_dist_d[p] = grp_dist_q[2*p];
        pair_idx_d[p]  = grp_idx_q[2*p];
      end
    end
  end

  // stage 5: final pick
  assign idx_d = (pair_dist_q[1] < pair_dist_q[0]) ? pair_idx_q[1] : pair_idx_q[0];

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) sq_q <= sq_d;
    if (ld_i.s2) dist_q <= dist_d;
    if (ld_i.s3) begin
      grp_dist_q <= grp_dist_d;
      grp_idx_q  <= grp_idx_d;
    end
    if (ld_i.s4) begin
      pair_dist_q <= pair_dist_d;
      pair_idx_q  <= pair_idx_d;
    end
    if (ld_i.s5) idx_q <= idx_d;
  end

  assign idx_o = idx_q;

endmodule

// ===== hdl/rgbtc_q256.sv =====
`timescale 1ns / 1ps

module rgbtc_q256 import rgbtc_pkg::*; (
  input  logic       clk_i,
  input  pipe_ld_t   ld_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [7:0] idx_o
);

  logic [7:0]  rgb_in [3];
  logic [7:0]  rgb1_q [3];
  logic [7:0]  rgb2_q [3];
  logic [7:0]  rgb3_q [3];
  logic [2:0]  lvl_d  [3];
  logic [2:0]  lvl1_q [3];
  logic [2:0]  lvl2_q [3];
  logic [2:0]  lvl3_q [3];
  logic [9:0]  sum_d, sum1_q;
  logic [15:0] csq_d [3];
  logic [15:0] csq2_q [3];
  logic [19:0] avg_prod;
  logic [7:0]  avg_d, avg2_q;
  logic [17:0] cdist_d, cdist3_q, cdist4_q;
  logic [7:0]  avg_ofs;
  logic [15:0] step_prod;
  logic [4:0]  step_raw;
  logic [4:0]  step_d, step3_q, step4_q;
  logic [7:0]  gray_val;
  logic [15:0] gsq_d [3];
  logic [15:0] gsq4_q [3];
  logic [7:0]  cidx_d, cidx4_q;
  logic [17:0] gdist;
  logic [7:0]  idx_d, idx_q;

  assign rgb_in[0] = red_i;
  assign rgb_in[1] = green_i;
  assign rgb_in[2] = blue_i;

  // stage 1: cube levels and channel sum
  always_comb begin
    for (int c = 0; c < 3; c++) lvl_d[c] = cube_level_of(rgb_in[c]);
    sum_d = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  end

  // stage 2: cube squares, average by reciprocal
  always_comb begin
    for (int c = 0; c < 3; c++) csq_d[c] = square8(abs_diff(rgb1_q[c], cube_value(lvl1_q[c])));
    avg_prod = 20'(sum1_q) * 20'(AVG_RECIP);
    avg_d    = avg_prod[RECIP_SHIFT +: 8];
  end

  // stage 3: cube distance, gray step clamped to the ramp
  always_comb begin
    cdist_d   = 18'(csq2_q[0]) + 18'(csq2_q[1]) + 18'(csq2_q[2]);
    avg_ofs   = avg2_q - GRAY_OFS;
    step_prod = 16'(avg_ofs) * 16'(STEP_RECIP);
    step_raw  = step_prod[RECIP_SHIFT +: 5];
    if (avg2_q < GRAY_OFS) begin
      step_d = 5'd0;
    end else if (step_raw > GRAY_MAX_STEP) begin
      step_d = GRAY_MAX_STEP;
    end else begin
      step_d = step_raw;
    end
  end

  // stage 4: gray squares and cube palette index
  always_comb begin
    gray_val = GRAY_FIRST + (8'(step3_q) << 3) + (8'(step3_q) << 1);
    for (int c = 0; c < 3; c++) gsq_d[c] = square8(abs_diff(rgb3_q[c], gray_val));
    cidx_d = CUBE_BASE + (8'(lvl3_q[0]) << 5) + (8'(lvl3_q[0]) << 2)
           + (8'(lvl3_q[1]) << 2) + (8'(lvl3_q[1]) << 1) + 8'(lvl3_q[2]);
  end

  // stage 5: gray only when strictly nearer
  always_comb begin
    gdist = 18'(gsq4_q[0]) + 18'(gsq4_q[1]) + 18'(gsq4_q[2]);
    idx_d = (gdist < cdist4_q) ? (GRAY_BASE + 8'(step4_q)) : cidx4_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      rgb1_q <= rgb_in;
      lvl1_q <= lvl_d;
      sum1_q <= sum_d;
    end
    if (ld_i.s2) begin
      rgb2_q <= rgb1_q;
      lvl2_q <= lvl1_q;
      csq2_q <= csq_d;
      avg2_q <= avg_d;
    end
    if (ld_i.s3) begin
      rgb3_q   <= rgb2_q;
      lvl3_q   <= lvl2_q;
      cdist3_q <= cdist_d;
      step3_q  <= step_d;
    end
    if (ld_i.s4) begin
      gsq4_q   <= gsq_d;
      cidx4_q  <= cidx_d;
      cdist4_q <= cdist3_q;
      step4_q  <= step3_q;
    end
    if (ld_i.s5) begin
      idx_q <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

// ===== hdl/rgb_to_terminal_color_code_top.sv =====
`timescale 1ns / 1ps

// Terminal color code generator. Each transfer on the input carries either a
// named 16-color index or an RGB triple plus a target (foreground, background,
// underline); each produces exactly one result transfer holding the color
// selection code for the mode in the color_mode register (off, 16 colors,
// 256-entry palette, truecolor). The datapath is a five-stage pipeline
// followed by the output register: one item is taken every cycle unless
// in_stall_o is raised. The 16-color search (squared distance to sixteen
// reference colors) and the palette search (color cube against gray ramp)
// run side by side in that pipeline. A stall on the output holds the output
// register and backs up stage by stage; empty stages keep filling, so the
// input stays open until the pipeline is full. Write color_mode only while
// no transfer is in flight.
module rgb_to_terminal_color_code_top import rgbtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  color_mode_e mode_q;

  // stage valid bits and the item carried alongside the search units
  logic [4:0] v_q;
  in_item_t   it_q [5];

  logic       out_v_q;
  out_item_t  out_q;
  out_item_t  out_d;

  logic       ld_out;
  pipe_ld_t   ld;

  logic [3:0] idx16;
  logic [7:0] idx256;

  logic       under;
  logic [6:0] ext_code;
  in_item_t   last;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
    end else if (cfg_we_i) begin
      mode_q <= color_mode_e'(cfg_data_i);
    end
  end

  // a stage loads when it is empty or its content moves on
  assign ld_out = !out_v_q || !out_stall_i;
  assign ld.s5  = !v_q[4] || ld_out;
  assign ld.s4  = !v_q[3] || ld.s5;
  assign ld.s3  = !v_q[2] || ld.s4;
  assign ld.s2  = !v_q[1] || ld.s3;
  assign ld.s1  = !v_q[0] || ld.s2;

  assign in_stall_o = !ld.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (ld.s1)  v_q[0]  <= in_valid_i;
      if (ld.s2)  v_q[1]  <= v_q[0];
      if (ld.s3)  v_q[2]  <= v_q[1];
      if (ld.s4)  v_q[3]  <= v_q[2];
      if (ld.s5)  v_q[4]  <= v_q[3];
      if (ld_out) out_v_q <= v_q[4];
    end
  end

  // item payload follows the valid bits
  always_ff @(posedge clk_i) begin
    if (ld.s1)  it_q[0] <= in_data_i;
    if (ld.s2)  it_q[1] <= it_q[0];
    if (ld.s3)  it_q[2] <= it_q[1];
    if (ld.s4)  it_q[3] <= it_q[2];
    if (ld.s5)  it_q[4] <= it_q[3];
    if (ld_out) out_q   <= out_d;
  end

  // nearest of the sixteen reference colors
  rgbtc_q16 u_q16 (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .red_i   (in_data_i.red),
    .green_i (in_data_i.green),
    .blue_i  (in_data_i.blue),
    .idx_o   (idx16)
  );

  // palette index: color cube or gray ramp
  rgbtc_q256 u_q256 (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .red_i   (in_data_i.red),
    .green_i (in_data_i.green),
    .blue_i  (in_data_i.blue),
    .idx_o   (idx256)
  );

  // result formatting from the item leaving stage 5
  assign last  = it_q[4];
  assign under = last.target[1];

  always_comb begin
    if (under) begin
      ext_code = SGR_EXT_UL;
    end else if (last.target == TGT_BG) begin
      ext_code = SGR_EXT_BG;
    end else begin
      ext_code = SGR_EXT_FG;
    end
  end

  always_comb begin
    out_d = '0;
    if (!(mode_q == MODE_OFF || (under && mode_q == MODE_16))) begin
      out_d.emit = 1'b1;
      if (last.is_named) begin
        if (under) begin
          out_d.form          = FORM_PALETTE;
          out_d.sgr_code      = SGR_EXT_UL;
          out_d.palette_index = {4'd0, last.named_index};
        end else begin
          out_d.form     = FORM_DIRECT;
          out_d.sgr_code = direct_code(last.named_index, last.target);
        end
      end else begin
        case (mode_q)
          MODE_TRUE: begin
            out_d.form      = FORM_TRUE;
            out_d.sgr_code  = ext_code;
            out_d.out_red   = last.red;
            out_d.out_green = last.green;
            out_d.out_blue  = last.blue;
          end
          MODE_256: begin
            out_d.form          = FORM_PALETTE;
            out_d.sgr_code      = ext_code;
            out_d.palette_index = idx256;
          end
          MODE_16: begin
            out_d.form     = FORM_DIRECT;
            out_d.sgr_code = direct_code(idx16, last.target);
          end
          default: begin
            out_d = '0;
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // a suppressed result carries all zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.emit |-> out_data_o.form == FORM_NONE &&
      out_data_o.sgr_code == '0 && out_data_o.palette_index == '0 &&
      out_data_o.out_red == '0 && out_data_o.out_green == '0 && out_data_o.out_blue == '0)
    else $error("suppressed result has nonzero fields");

  // truecolor form only in truecolor mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.form == FORM_TRUE |-> mode_q == MODE_TRUE)
    else $error("truecolor form outside truecolor mode");

  // extended forms use an introducer code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.form == FORM_PALETTE || out_data_o.form == FORM_TRUE) |->
      out_data_o.sgr_code == SGR_EXT_FG || out_data_o.sgr_code == SGR_EXT_BG ||
      out_data_o.sgr_code == SGR_EXT_UL)
    else $error("extended form without introducer");

  // direct codes stay in the standard range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.form == FORM_DIRECT |->
      out_data_o.sgr_code >= SGR_FG_BASE && out_data_o.sgr_code <= SGR_DIRECT_MAX)
    else $error("direct code out of range");

  // an accepted transfer lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted transfer lost at pipeline entry");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// checks the terminal color code generator against an in-bench predictor:
// a queue-fed driver offers color items, a monitor compares every result
// transfer with the oldest expected code, and the stimulus walks through all
// four color modes under different amounts of idling on both sides
module tb;
  import rgbtc_pkg::*;

  // long receiver hold-off that lets the pipeline fill and stall its input
  localparam int HOLD_CYCLES = 80;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  in_item_t   in_data = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  out_item_t  out_data_o;

  // items waiting for the driver, and codes waiting for the monitor
  in_item_t    pending_colors[$];
  out_item_t   expected_codes[$];

  // mode the predictor works with, follows every register write
  color_mode_e mode_shadow = MODE_OFF;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  logic        recv_hold = 1'b0;
  int          error_count = 0;

  rgb_to_terminal_color_code_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // the sixteen reference colors, packed as red, green, blue
  function automatic logic [23:0] ref16_color(input int idx);
    case (idx)
      0:       return 24'h000000;
      1:       return 24'hCD0000;
      2:       return 24'h00CD00;
      3:       return 24'hCDCD00;
      4:       return 24'h0000EE;
      5:       return 24'hCD00CD;
      6:       return 24'h00CDCD;
      7:       return 24'hE5E5E5;
      8:       return 24'h7F7F7F;
      9:       return 24'hFF0000;
      10:      return 24'h00FF00;
      11:      return 24'hFFFF00;
      12:      return 24'h5C5CFF;
      13:      return 24'hFF00FF;
      14:      return 24'h00FFFF;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic int color_dist(input int r, input int g, input int b,
                                    input int rr, input int gg, input int bb);
    return (r - rr) * (r - rr) + (g - gg) * (g - gg) + (b - bb) * (b - bb);
  endfunction

  // nearest reference color, strict compare keeps the lower index on a tie
  function automatic int nearest_ref16(input int r, input int g, input int b);
    int best;
    int best_d;
    int d;
    logic [23:0] c;
    best = 0;
    best_d = color_dist(r, g, b, 0, 0, 0);
    for (int i = 1; i < 16; i++) begin
      c = ref16_color(i);
      d = color_dist(r, g, b, int'(c[23:16]), int'(c[15:8]), int'(c[7:0]));
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  // cube step: number of midpoints at or below the channel value
  function automatic int cube_step(input int v);
    return int'(v >= 48) + int'(v >= 115) + int'(v >= 155) + int'(v >= 195) +
           int'(v >= 235);
  endfunction

  function automatic int cube_level_value(input int lv);
    return (lv == 0) ? 0 : 55 + 40 * lv;
  endfunction

  // palette entry: cube color unless the gray ramp is strictly nearer
  function automatic int nearest_palette(input int r, input int g, input int b);
    int lr;
    int lg;
    int lb;
    int avg;
    int step;
    int gv;
    lr = cube_step(r);
    lg = cube_step(g);
    lb = cube_step(b);
    avg = (r + g + b) / 3;
    step = (avg < 3) ? 0 : (avg - 3) / 10;
    if (step > 23) step = 23;
    gv = 8 + 10 * step;
    if (color_dist(r, g, b, gv, gv, gv) <
        color_dist(r, g, b, cube_level_value(lr), cube_level_value(lg),
                   cube_level_value(lb)))
      return 232 + step;
    return 16 + 36 * lr + 6 * lg + lb;
  endfunction

  function automatic logic [6:0] direct_sgr(input int idx, input logic [1:0] tgt);
    int code;
    code = (tgt == TGT_BG) ? int'(SGR_BG_BASE) : int'(SGR_FG_BASE);
    if (idx >= 8) code = code + int'(SGR_BRIGHT);
    return 7'(code + idx % 8);
  endfunction

  // expected result transfer for one input item in the given mode
  function automatic out_item_t terminal_code_of(input in_item_t it,
                                                 input color_mode_e mode);
    out_item_t  res;
    logic       under;
    logic [6:0] intro;
    res = '0;
    // target values 2 and 3 both mean underline
    under = it.target[1];
    intro = under ? SGR_EXT_UL : ((it.target == TGT_BG) ? SGR_EXT_BG : SGR_EXT_FG);
    if (mode == MODE_OFF || (under && mode == MODE_16)) return res;
    res.emit = 1'b1;
    if (it.is_named) begin
      if (under) begin
        res.form = FORM_PALETTE;
        res.sgr_code = SGR_EXT_UL;
        res.palette_index = {4'd0, it.named_index};
      end else begin
        res.form = FORM_DIRECT;
        res.sgr_code = direct_sgr(int'(it.named_index), it.target);
      end
      return res;
    end
    case (mode)
      MODE_TRUE: begin
        res.form = FORM_TRUE;
        res.sgr_code = intro;
        res.out_red = it.red;
        res.out_green = it.green;
        res.out_blue = it.blue;
      end
      MODE_256: begin
        res.form = FORM_PALETTE;
        res.sgr_code = intro;
        res.palette_index = 8'(nearest_palette(int'(it.red), int'(it.green),
                                               int'(it.blue)));
      end
      default: begin
        res.form = FORM_DIRECT;
        res.sgr_code = direct_sgr(nearest_ref16(int'(it.red), int'(it.green),
                                                int'(it.blue)), it.target);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued items, holds a stalled item unchanged, and records
  // the expected code at the edge where the transfer happens
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!(in_valid && in_stall_o)) begin
      if (in_valid) expected_codes.push_back(terminal_code_of(in_data, mode_shadow));
      if (pending_colors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_colors.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, forced high during the hold-off
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one long hold-off, counted here, started by the stimulus
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer against the oldest expected code
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_codes.pop_front();
        if (out_data_o.emit !== want.emit)
          report_mismatch("emit", int'(out_data_o.emit), int'(want.emit));
        if (out_data_o.form !== want.form)
          report_mismatch("form", int'(out_data_o.form), int'(want.form));
        if (out_data_o.sgr_code !== want.sgr_code)
          report_mismatch("sgr_code", int'(out_data_o.sgr_code), int'(want.sgr_code));
        if (out_data_o.palette_index !== want.palette_index)
          report_mismatch("palette_index", int'(out_data_o.palette_index),
                          int'(want.palette_index));
        if (out_data_o.out_red !== want.out_red)
          report_mismatch("out_red", int'(out_data_o.out_red), int'(want.out_red));
        if (out_data_o.out_green !== want.out_green)
          report_mismatch("out_green", int'(out_data_o.out_green), int'(want.out_green));
        if (out_data_o.out_blue !== want.out_blue)
          report_mismatch("out_blue", int'(out_data_o.out_blue), int'(want.out_blue));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_color(input logic named, input int idx, input int r, input int g,
                           input int b, input logic [1:0] tgt);
    in_item_t it;
    it.is_named = named;
    it.named_index = 4'(idx);
    it.red = 8'(r);
    it.green = 8'(g);
    it.blue = 8'(b);
    it.target = tgt;
    pending_colors.push_back(it);
  endtask

  // channel value right at a cube midpoint or one below it
  function automatic int boundary_channel();
    int mids[5];
    mids = '{48, 115, 155, 195, 235};
    return mids[$urandom_range(4)] - int'($urandom_range(1));
  endfunction

  function automatic in_item_t random_color();
    in_item_t it;
    int       shape;
    int       base;
    it.is_named = ($urandom_range(3) == 0);
    it.named_index = 4'($urandom_range(15));
    it.target = 2'($urandom_range(3));
    shape = $urandom_range(7);
    if (shape < 2) begin
      // near gray, where the ramp competes with the cube
      base = $urandom_range(255);
      it.red = 8'(base);
      it.green = 8'(base ^ $urandom_range(3));
      it.blue = 8'(base ^ $urandom_range(3));
    end else if (shape == 2) begin
      it.red = 8'(boundary_channel());
      it.green = 8'(boundary_channel());
      it.blue = 8'(boundary_channel());
    end else begin
      it.red = 8'($urandom_range(255));
      it.green = 8'($urandom_range(255));
      it.blue = 8'($urandom_range(255));
    end
    return it;
  endfunction

  // waits until every queued item went in and every expected code came out
  task automatic drain();
    while (pending_colors.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // register write while the pipeline is empty
  task automatic write_mode(input color_mode_e m);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic random_phase(input color_mode_e m, input int count, input int idle_pct,
                              input int stall_pct);
    write_mode(m);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_colors.push_back(random_color());
    drain();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // no color right after reset: nothing is emitted
    add_color(1'b1, 15, 0, 0, 0, TGT_BG);
    add_color(1'b0, 0, 255, 255, 255, 2'd2);
    drain();

    write_mode(MODE_16);
    add_color(1'b1, 0, 0, 0, 0, TGT_FG);
    add_color(1'b1, 15, 255, 255, 255, TGT_BG);
    // underline has no direct code in this mode
    add_color(1'b1, 8, 0, 0, 0, 2'd2);
    add_color(1'b0, 0, 255, 0, 0, 2'd3);
    add_color(1'b0, 0, 0, 0, 0, TGT_FG);
    add_color(1'b0, 0, 255, 255, 255, TGT_BG);
    // equally far from dark and bright red, the lower index wins
    add_color(1'b0, 0, 230, 0, 0, TGT_FG);
    add_color(1'b0, 0, 127, 127, 127, TGT_FG);
    drain();

    write_mode(MODE_256);
    add_color(1'b1, 7, 0, 0, 0, 2'd2);
    add_color(1'b1, 12, 0, 0, 0, TGT_FG);
    add_color(1'b0, 0, 0, 0, 0, TGT_FG);
    add_color(1'b0, 0, 255, 255, 255, TGT_BG);
    add_color(1'b0, 0, 47, 48, 114, TGT_FG);
    add_color(1'b0, 0, 115, 234, 235, 2'd2);
    // mid gray lands exactly on a ramp step
    add_color(1'b0, 0, 128, 128, 128, TGT_BG);
    // ramp and cube equally far, the cube wins
    add_color(1'b0, 0, 4, 4, 4, TGT_FG);
    drain();

    write_mode(MODE_TRUE);
    add_color(1'b0, 0, 255, 0, 128, TGT_FG);
    add_color(1'b0, 0, 0, 255, 1, TGT_BG);
    add_color(1'b0, 0, 1, 2, 254, 2'd3);
    add_color(1'b1, 9, 0, 0, 0, 2'd3);
    add_color(1'b1, 3, 255, 255, 255, TGT_FG);
    drain();

    random_phase(MODE_TRUE, 80, 0, 0);
    random_phase(MODE_16, 100, 70, 0);
    random_phase(MODE_256, 120, 0, 70);
    random_phase(MODE_256, 100, 22, 22);

    // sender keeps offering while the receiver holds off for a long stretch
    write_mode(MODE_16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 100; i++) pending_colors.push_back(random_color());
    hold_start = 1'b1;
    drain();

    random_phase(MODE_OFF, 40, 0, 22);
    random_phase(MODE_TRUE, 60, 22, 22);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
